### rtl/mfts_pkg.sv
// shared types and constants of the multilevel feedback thread scheduler
package mfts_pkg;

   localparam int TID_W = 4;
   localparam logic [4:0] LIVE_MAX = 5'd31;

   localparam logic [2:0] OP_NEW     = 3'd0;
   localparam logic [2:0] OP_BLOCK   = 3'd1;
   localparam logic [2:0] OP_END     = 3'd2;
   localparam logic [2:0] OP_UNBLOCK = 3'd3;
   localparam logic [2:0] OP_TIMER   = 3'd4;

   typedef struct packed {
      logic [2:0]       opcode;
      logic [TID_W-1:0] thread_id;
      logic [3:0]       block_event;
   } req_type;

   typedef struct packed {
      logic             switched;
      logic [TID_W-1:0] previous_thread;
      logic [TID_W-1:0] next_thread;
      logic             fault;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic push_lvl;
      logic new_count;
      logic be;
      logic cur_from_f;
      logic push_rdy_t;
      logic sel_dst;
      logic sel_cur;
      logic pop_lvl;
      logic move;
      logic set_change;
      logic rdy_read;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       scan_hit;
      logic       scan_last;
      logic       found;
      logic       live_nz;
   } stat_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_NEW, ST_BE, ST_UNB, ST_TMR, ST_DST, ST_PUSHL,
      ST_POP, ST_MOVE, ST_RSEL, ST_FIN
   } state_type;

endpackage

### rtl/mfts_ctrl.sv
// sequencer that steps the scheduler datapath through one event
module mfts_ctrl import mfts_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  req_type  req_data,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_data.opcode)
                  OP_NEW: state_in = ST_NEW;
                  OP_BLOCK, OP_END, OP_UNBLOCK, OP_TIMER: state_in = ST_SCAN;
                  default: state_in = ST_RSEL;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit || stat.scan_last) begin
               case (stat.op)
                  OP_BLOCK, OP_END: state_in = ST_BE;
                  OP_UNBLOCK: state_in = ST_UNB;
                  default: state_in = ST_TMR;
               endcase
            end
         end
         ST_NEW: begin
            cmd.push_lvl  = 1'b1;
            cmd.new_count = 1'b1;
            state_in      = ST_RSEL;
         end
         ST_BE: begin
            cmd.be   = 1'b1;
            state_in = stat.found ? ST_POP : ST_RSEL;
         end
         ST_UNB: begin
            cmd.push_rdy_t = 1'b1;
            cmd.cur_from_f = 1'b1;
            state_in       = ST_DST;
         end
         ST_TMR: begin
            if (stat.live_nz) begin
               cmd.cur_from_f = 1'b1;
               cmd.set_change = 1'b1;
               state_in       = ST_DST;
            end else begin
               state_in = ST_RSEL;
            end
         end
         ST_DST: begin
            cmd.sel_dst = 1'b1;
            state_in    = ST_PUSHL;
         end
         ST_PUSHL: begin
            cmd.push_lvl = 1'b1;
            if (stat.op == OP_TIMER) begin
               cmd.sel_cur = 1'b1;
               state_in    = ST_POP;
            end else begin
               state_in = ST_RSEL;
            end
         end
         ST_POP: begin
            cmd.pop_lvl = 1'b1;
            state_in    = ST_MOVE;
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = ST_RSEL;
         end
         ST_RSEL: begin
            cmd.rdy_read = 1'b1;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### rtl/mfts_dp.sv
// scheduler datapath: level and ready queues, counters and result register
module mfts_dp import mfts_pkg::*; #(
   parameter int MAX_THREADS = 16,
   parameter int LEVELS      = 20
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp_data
);

   localparam int HW = $clog2(MAX_THREADS);
   localparam int FW = $clog2(MAX_THREADS + 1);
   localparam int LW = $clog2(LEVELS);
   localparam int AW = $clog2(LEVELS * MAX_THREADS);
   localparam logic [FW-1:0] FULL = FW'(MAX_THREADS);
   localparam logic [LW-1:0] LAST = LW'(LEVELS - 1);

   function automatic logic [HW-1:0] wrap(input logic [HW-1:0] h, input logic [FW-1:0] n);
      logic [FW:0] s;
      s = {{(FW + 1 - HW){1'b0}}, h} + {1'b0, n};
      if (s >= (FW + 1)'(MAX_THREADS)) s = s - (FW + 1)'(MAX_THREADS);
      return s[HW-1:0];
   endfunction

   function automatic logic [AW-1:0] laddr(input logic [LW-1:0] l, input logic [HW-1:0] i);
      return AW'(int'(l) * MAX_THREADS + int'(i));
   endfunction

   logic [2:0]       op_ff, op_in;
   logic [TID_W-1:0] tid_ff, tid_in;
   logic [HW-1:0]    lvl_head_ff [LEVELS];
   logic [HW-1:0]    lvl_head_in [LEVELS];
   logic [FW-1:0]    lvl_fill_ff [LEVELS];
   logic [FW-1:0]    lvl_fill_in [LEVELS];
   logic [HW-1:0]    rdy_head_ff, rdy_head_in;
   logic [FW-1:0]    rdy_fill_ff, rdy_fill_in;
   logic [LW-1:0]    cur_ff, cur_in, sel_ff, sel_in, idx_ff, idx_in, f_ff, f_in;
   logic             found_ff, found_in, fault_ff, fault_in, change_ff, change_in;
   logic             sw_ff, sw_in, pend_ff, pend_in, started_ff, started_in;
   logic [4:0]       live_ff, live_in;
   logic [TID_W-1:0] run_ff, run_in;
   rsp_type          rsp_ff, rsp_in;

   logic [TID_W-1:0] lvl_mem [LEVELS * MAX_THREADS];
   logic [TID_W-1:0] rdy_mem [MAX_THREADS];
   logic             lvl_we, lvl_re, rdy_we, rdy_re;
   logic [AW-1:0]    lvl_waddr, lvl_raddr;
   logic [HW-1:0]    rdy_waddr, rdy_raddr;
   logic [TID_W-1:0] lvl_wdata, rdy_wdata, lvl_rdata_ff, rdy_rdata_ff;

   always_ff @(posedge clock) begin
      if (lvl_we) lvl_mem[lvl_waddr] <= lvl_wdata;
      if (lvl_re) lvl_rdata_ff <= lvl_mem[lvl_raddr];
      if (rdy_we) rdy_mem[rdy_waddr] <= rdy_wdata;
      if (rdy_re) rdy_rdata_ff <= rdy_mem[rdy_raddr];
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      tid_ff <= tid_in;
      rsp_ff <= rsp_in;
      sel_ff <= sel_in;
      idx_ff <= idx_in;
      f_ff   <= f_in;
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            lvl_head_ff[i] <= '0;
            lvl_fill_ff[i] <= '0;
         end
         rdy_head_ff <= '0;
         rdy_fill_ff <= '0;
         cur_ff      <= '0;
         found_ff    <= 1'b0;
         fault_ff    <= 1'b0;
         change_ff   <= 1'b0;
         sw_ff       <= 1'b0;
         pend_ff     <= 1'b0;
         started_ff  <= 1'b0;
         live_ff     <= '0;
         run_ff      <= '0;
      end else begin
         lvl_head_ff <= lvl_head_in;
         lvl_fill_ff <= lvl_fill_in;
         rdy_head_ff <= rdy_head_in;
         rdy_fill_ff <= rdy_fill_in;
         cur_ff      <= cur_in;
         found_ff    <= found_in;
         fault_ff    <= fault_in;
         change_ff   <= change_in;
         sw_ff       <= sw_in;
         pend_ff     <= pend_in;
         started_ff  <= started_in;
         live_ff     <= live_in;
         run_ff      <= run_in;
      end
   end

   always_comb begin
      op_in       = op_ff;
      tid_in      = tid_ff;
      lvl_head_in = lvl_head_ff;
      lvl_fill_in = lvl_fill_ff;
      rdy_head_in = rdy_head_ff;
      rdy_fill_in = rdy_fill_ff;
      cur_in      = cur_ff;
      sel_in      = sel_ff;
      idx_in      = idx_ff;
      f_in        = f_ff;
      found_in    = found_ff;
      fault_in    = fault_ff;
      change_in   = change_ff;
      sw_in       = sw_ff;
      pend_in     = pend_ff;
      started_in  = started_ff;
      live_in     = live_ff;
      run_in      = run_ff;
      rsp_in      = rsp_ff;
      lvl_we      = 1'b0;
      lvl_re      = 1'b0;
      rdy_we      = 1'b0;
      rdy_re      = 1'b0;
      lvl_waddr   = '0;
      lvl_raddr   = '0;
      rdy_waddr   = '0;
      rdy_raddr   = '0;
      lvl_wdata   = tid_ff;
      rdy_wdata   = tid_ff;

      if (cmd.load) begin
         op_in     = req_data.opcode;
         tid_in    = req_data.thread_id;
         fault_in  = 1'b0;
         change_in = 1'b0;
         sw_in     = 1'b0;
         found_in  = 1'b0;
         pend_in   = 1'b0;
         idx_in    = '0;
         sel_in    = '0;
      end
      if (cmd.scan_step) begin
         if (lvl_fill_ff[idx_ff] != '0) begin
            found_in = 1'b1;
            f_in     = idx_ff;
         end else if (idx_ff != LAST) begin
            idx_in = idx_ff + LW'(1);
         end
      end
      if (cmd.push_lvl) begin
         if (lvl_fill_ff[sel_ff] >= FULL) begin
            fault_in = 1'b1;
         end else begin
            lvl_we              = 1'b1;
            lvl_waddr           = laddr(sel_ff, wrap(lvl_head_ff[sel_ff], lvl_fill_ff[sel_ff]));
            lvl_fill_in[sel_ff] = lvl_fill_ff[sel_ff] + FW'(1);
         end
      end
      if (cmd.new_count) begin
         if (!started_ff) started_in = 1'b1;
         else if (live_ff < LIVE_MAX) live_in = live_ff + 5'd1;
      end
      if (cmd.be) begin
         if (op_ff == OP_END && live_ff != '0) live_in = live_ff - 5'd1;
         if (found_ff) begin
            if (op_ff == OP_BLOCK) cur_in = f_ff;
            sel_in    = f_ff;
            change_in = 1'b1;
         end
      end
      if (cmd.cur_from_f && found_ff) cur_in = f_ff;
      if (cmd.push_rdy_t) begin
         if (rdy_fill_ff >= FULL) begin
            fault_in = 1'b1;
         end else begin
            rdy_we      = 1'b1;
            rdy_waddr   = wrap(rdy_head_ff, rdy_fill_ff);
            rdy_fill_in = rdy_fill_ff + FW'(1);
         end
      end
      if (cmd.sel_dst) sel_in = (cur_ff == LAST) ? LAST : cur_ff + LW'(1);
      if (cmd.sel_cur) sel_in = cur_ff;
      if (cmd.pop_lvl) begin
         if (rdy_fill_ff >= FULL || lvl_fill_ff[sel_ff] == '0) begin
            fault_in = 1'b1;
         end else begin
            lvl_re              = 1'b1;
            lvl_raddr           = laddr(sel_ff, lvl_head_ff[sel_ff]);
            lvl_head_in[sel_ff] = wrap(lvl_head_ff[sel_ff], FW'(1));
            lvl_fill_in[sel_ff] = lvl_fill_ff[sel_ff] - FW'(1);
            pend_in             = 1'b1;
         end
      end
      if (cmd.move && pend_ff) begin
         rdy_we      = 1'b1;
         rdy_waddr   = wrap(rdy_head_ff, rdy_fill_ff);
         rdy_wdata   = lvl_rdata_ff;
         rdy_fill_in = rdy_fill_ff + FW'(1);
         pend_in     = 1'b0;
      end
      if (cmd.set_change) change_in = 1'b1;
      if (cmd.rdy_read && change_ff && !fault_ff) begin
         if (rdy_fill_ff == '0) begin
            fault_in = 1'b1;
         end else begin
            rdy_re      = 1'b1;
            rdy_raddr   = rdy_head_ff;
            rdy_head_in = wrap(rdy_head_ff, FW'(1));
            rdy_fill_in = rdy_fill_ff - FW'(1);
            sw_in       = 1'b1;
         end
      end
      if (cmd.out_load) begin
         rsp_in.switched        = sw_ff;
         rsp_in.fault           = fault_ff;
         rsp_in.previous_thread = sw_ff ? run_ff : '0;
         rsp_in.next_thread     = sw_ff ? rdy_rdata_ff : '0;
         if (sw_ff) run_in = rdy_rdata_ff;
      end
   end

   assign stat.op        = op_ff;
   assign stat.scan_hit  = (lvl_fill_ff[idx_ff] != '0);
   assign stat.scan_last = (idx_ff == LAST);
   assign stat.found     = found_ff;
   assign stat.live_nz   = (live_ff != '0);
   assign rsp_data       = rsp_ff;

endmodule

### rtl/multilevel_feedback_thread_scheduler.sv
// top level of the multilevel feedback thread scheduler
//
//   channel  direction  handshake                payload
//   req      in         req_valid / req_stall    req_data  (opcode, thread_id, block_event)
//   rsp      out        rsp_valid / rsp_stall    rsp_data  (switched, previous, next, fault)
//
// one event at a time; events other than new and unknown opcodes start with
// the level scan, one level a cycle, followed by queue memory accesses with
// registered reads
// synchronous reset empties all queues; no clearing pass is needed
// a stalled rsp beat holds; the next req beat is taken while it waits
module multilevel_feedback_thread_scheduler import mfts_pkg::*; #(
   parameter int MAX_THREADS = 16,
   parameter int LEVELS      = 20
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   mfts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mfts_dp #(
      .MAX_THREADS (MAX_THREADS),
      .LEVELS      (LEVELS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

### rtl/mfts_checker.sv
// port level checks of the scheduler and their bind
module mfts_checker import mfts_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled rsp beat dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled rsp beat changed");

   a_fault_no_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault |-> !rsp_data.switched)
      else $error("switch reported with fault");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.switched |->
         rsp_data.previous_thread == '0 && rsp_data.next_thread == '0)
      else $error("thread fields set without switch");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind multilevel_feedback_thread_scheduler mfts_checker u_mfts_checker (.*);

### test/tb.sv
// testbench of the multilevel feedback thread scheduler: event stimulus checked against a scheduling predictor
module tb;
   import mfts_pkg::*;

   localparam int NTHR = 16;
   localparam int NLVL = 20;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   multilevel_feedback_thread_scheduler DUT (.*);

   always #5 clock = ~clock;

   // scheduler state mirror
   logic [3:0] lvl_q [NLVL][NTHR];
   int         lvl_head [NLVL];
   int         lvl_fill [NLVL];
   logic [3:0] rdy_q [NTHR];
   int         rdy_head, rdy_fill;
   int         cur_lvl, live_cnt;
   bit         started;
   logic [3:0] running;

   rsp_type    expected_rsps [$];
   int         errors = 0;
   bit         quiet = 0;   // sender idling disabled

   function automatic bit q_push(ref logic [3:0] st [NTHR], ref int hd, ref int fl,
                                 input logic [3:0] v);
      if (fl >= NTHR) return 0;
      st[(hd + fl) % NTHR] = v;
      fl++;
      return 1;
   endfunction

   function automatic int first_busy_level();
      for (int i = 0; i < NLVL; i++)
         if (lvl_fill[i] != 0) return i;
      return NLVL;
   endfunction

   function automatic bit level_to_ready(int lv);
      logic [3:0] v;
      if (rdy_fill >= NTHR || lvl_fill[lv] == 0) return 0;
      v = lvl_q[lv][lvl_head[lv]];
      lvl_head[lv] = (lvl_head[lv] + 1) % NTHR;
      lvl_fill[lv]--;
      return q_push(rdy_q, rdy_head, rdy_fill, v);
   endfunction

   function automatic bit demote(logic [3:0] t);
      int f, d;
      f = first_busy_level();
      if (f < NLVL) cur_lvl = f;
      d = (cur_lvl + 1 >= NLVL) ? NLVL - 1 : cur_lvl + 1;
      return q_push(lvl_q[d], lvl_head[d], lvl_fill[d], t);
   endfunction

   function automatic rsp_type schedule(req_type r);
      rsp_type o;
      bit flt, chg;
      int f;
      o = '0; flt = 0; chg = 0;
      case (r.opcode)
         OP_NEW: begin
            if (!q_push(lvl_q[0], lvl_head[0], lvl_fill[0], r.thread_id)) flt = 1;
            if (!started) started = 1;
            else if (live_cnt < 31) live_cnt++;
         end
         OP_BLOCK, OP_END: begin
            if (r.opcode == OP_END && live_cnt > 0) live_cnt--;
            f = first_busy_level();
            if (f < NLVL) begin
               if (r.opcode == OP_BLOCK) cur_lvl = f;
               if (level_to_ready(f)) chg = 1;
               else flt = 1;
            end
         end
         OP_UNBLOCK: begin
            if (!q_push(rdy_q, rdy_head, rdy_fill, r.thread_id)) flt = 1;
            if (!demote(r.thread_id)) flt = 1;
         end
         OP_TIMER: begin
            if (live_cnt > 0) begin
               if (!demote(r.thread_id)) flt = 1;
               if (!level_to_ready(cur_lvl)) flt = 1;
               chg = 1;
            end
         end
         default: ;
      endcase
      if (chg && !flt) begin
         if (rdy_fill != 0) begin
            o.switched = 1;
            o.previous_thread = running;
            o.next_thread = rdy_q[rdy_head];
            running = rdy_q[rdy_head];
            rdy_head = (rdy_head + 1) % NTHR;
            rdy_fill--;
         end else flt = 1;
      end
      o.fault = flt;
      return o;
   endfunction

   task automatic send_event(logic [2:0] op, logic [3:0] t, logic [3:0] ev = 4'($urandom));
      req_type r;
      r.opcode = op; r.thread_id = t; r.block_event = ev;
      while (!quiet && $urandom_range(99) < 20) @(posedge clock);
      req_valid <= 1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps.push_back(schedule(r));
      req_valid <= 0;
      // the block is busy for this edge anyway
      @(posedge clock);
   endtask

   task automatic drain();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // result stall and checking
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result beat");
               errors++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_data.switched !== e.switched) begin
                  $error("switched exp %0h got %0h", e.switched, rsp_data.switched); errors++;
               end
               if (rsp_data.previous_thread !== e.previous_thread) begin
                  $error("previous_thread exp %0h got %0h", e.previous_thread,
                         rsp_data.previous_thread); errors++;
               end
               if (rsp_data.next_thread !== e.next_thread) begin
                  $error("next_thread exp %0h got %0h", e.next_thread,
                         rsp_data.next_thread); errors++;
               end
               if (rsp_data.fault !== e.fault) begin
                  $error("fault exp %0h got %0h", e.fault, rsp_data.fault); errors++;
               end
            end
         end
         rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 20);
      end
   end

   task automatic test_directed();
      send_event(OP_TIMER, 4'd0, 4'hF);
      send_event(OP_BLOCK, 4'd0, 4'h0);
      send_event(OP_END, 4'd15);
      send_event(OP_NEW, 4'd0);
      send_event(OP_NEW, 4'd15);
      send_event(OP_NEW, 4'd7);
      send_event(OP_TIMER, 4'd0);
      send_event(OP_BLOCK, 4'd15);
      send_event(OP_UNBLOCK, 4'd15);
      send_event(OP_TIMER, 4'd7);
      send_event(OP_END, 4'd7);
      send_event(3'd5, 4'd3);
      send_event(3'd7, 4'd15);
      for (int i = 0; i < 12; i++) send_event(OP_UNBLOCK, 4'(i)); // ready queue fill
   endtask

   task automatic test_overflow();
      for (int i = 0; i < 18; i++) send_event(OP_NEW, 4'($urandom));
      for (int i = 0; i < 25; i++) send_event(OP_TIMER, 4'($urandom)); // deep levels
      drain();
   endtask

   task automatic test_random(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         quiet = (i >= n / 3 && i < n / 3 + 80);
         if (i == n / 2) drain();
         k = $urandom_range(99);
         if (k < 20) send_event(OP_NEW, 4'($urandom));
         else if (k < 40) send_event(OP_BLOCK, 4'($urandom));
         else if (k < 55) send_event(OP_END, 4'($urandom));
         else if (k < 72) send_event(OP_UNBLOCK, 4'($urandom));
         else if (k < 95) send_event(OP_TIMER, 4'($urandom));
         else send_event(3'($urandom_range(7, 5)), 4'($urandom));
      end
      quiet = 0;
   endtask

   initial begin
      for (int i = 0; i < NLVL; i++) begin
         lvl_head[i] = 0; lvl_fill[i] = 0;
      end
      rdy_head = 0; rdy_fill = 0; cur_lvl = 0; live_cnt = 0; started = 0; running = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_random(480);
      drain();
      if (errors == 0) $display("** multilevel_feedback_thread_scheduler: PASSED **");
      else $display("** multilevel_feedback_thread_scheduler: FAILED **");
      $finish;
   end

   initial begin
      #2000000;
      $display("** multilevel_feedback_thread_scheduler: FAILED **");
      $finish;
   end
endmodule
